[design/assert_macros.svh]
// Assertion macros used by the window_stack_order_and_hit_test design file.
// Defining NO_ASSERTIONS turns every macro into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, ck, rn, expr, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, ck, rn, expr, msg)
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

[design/wsht_pkg.sv]
// Package for the window stack and hit test block: sizes, commands, cell types.
// Used by wsht_cell and window_stack_order_and_hit_test; depends on nothing.
`timescale 1ns / 1ps

package wsht_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int COORD_BITS  = 12;

    localparam int ID_BITS  = (MAX_WINDOWS > 2) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_BITS = $clog2(MAX_WINDOWS + 1);

    // Fixed widths of the transaction fields.
    localparam int CMD_BITS       = 2;
    localparam int WID_BITS       = 4;
    localparam int LEVEL_BITS     = 6;
    localparam int HIT_BITS       = 4;
    localparam int COUNT_OUT_BITS = 5;
    localparam int WLEVEL_BITS    = 5;

    // Signed width that holds both a requested level and the stack count.
    localparam int REQ_BITS = ((CNT_BITS + 1) > LEVEL_BITS) ? (CNT_BITS + 1) : LEVEL_BITS;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_SET_SIZE  = 2'd0,
        CMD_MOVE      = 2'd1,
        CMD_SET_LEVEL = 2'd2,
        CMD_HIT_TEST  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_PREV = 2'd1,
        OP_NEXT = 2'd2,
        OP_LOAD = 2'd3
    } cell_op_t;

    // One stack entry: the window slot and a copy of its rectangle.
    typedef struct packed {
        logic [ID_BITS-1:0]           id;
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0]        width;
        logic [COORD_BITS-1:0]        tall;
    } cell_data_t;

    // Values broadcast to every cell of the row.
    typedef struct packed {
        logic                         move_en;
        logic [ID_BITS-1:0]           sel_id;
        logic signed [COORD_BITS-1:0] new_left;
        logic signed [COORD_BITS-1:0] new_top;
        logic signed [COORD_BITS-1:0] probe_x;
        logic signed [COORD_BITS-1:0] probe_y;
    } cell_bcast_t;

endpackage

[design/window_stack_order_and_hit_test.sv]
// The block takes one transaction at a time; the next one is accepted only when the block is back
// in S_IDLE. After the accepting edge, S_LOOK finds the addressed window in the row of stack cells
// and clamps the requested level, S_APPLY shifts the whole row by at most one place, and S_RESULT
// picks the highest covering cell above the bottom entry and below the topmost one and loads the
// output register. A result that waits in the output register does not hold up the next
// transaction until its own result is ready; a stalled output then holds the block in its last
// cycle. Depends on wsht_pkg, wsht_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module window_stack_order_and_hit_test (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic [wsht_pkg::CMD_BITS-1:0]               cmd,
    input  logic [wsht_pkg::WID_BITS-1:0]               window_id,
    input  logic signed [wsht_pkg::COORD_BITS-1:0]      pos_x,
    input  logic signed [wsht_pkg::COORD_BITS-1:0]      pos_y,
    input  logic [wsht_pkg::COORD_BITS-1:0]             size_w,
    input  logic [wsht_pkg::COORD_BITS-1:0]             size_h,
    input  logic signed [wsht_pkg::LEVEL_BITS-1:0]      level,
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic                                        hit_found,
    output logic [wsht_pkg::HIT_BITS-1:0]               hit_window,
    output logic [wsht_pkg::COUNT_OUT_BITS-1:0]         shown_count,
    output logic signed [wsht_pkg::WLEVEL_BITS-1:0]     window_level
);
    import wsht_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOK   = 4'b0010,
        S_APPLY  = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    localparam logic signed [REQ_BITS-1:0] REQ_ONE       = REQ_BITS'(1);
    localparam logic signed [REQ_BITS-1:0] REQ_MINUS_ONE = REQ_BITS'(-1);

    state_t state_reg;
    state_t state_next;

    // Transaction registers.
    cmd_t                         cmd_reg;
    logic [WID_BITS-1:0]          id_reg;
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic [COORD_BITS-1:0]        sw_reg;
    logic [COORD_BITS-1:0]        sh_reg;
    logic signed [LEVEL_BITS-1:0] lvl_reg;

    // Window table, indexed by slot.
    logic signed [COORD_BITS-1:0] tab_left_reg  [MAX_WINDOWS];
    logic signed [COORD_BITS-1:0] tab_top_reg   [MAX_WINDOWS];
    logic [COORD_BITS-1:0]        tab_width_reg [MAX_WINDOWS];
    logic [COORD_BITS-1:0]        tab_tall_reg  [MAX_WINDOWS];

    logic [CNT_BITS-1:0]          count_reg;
    logic [CNT_BITS-1:0]          count_next;

    // Results of the lookup cycle.
    logic                         do_level_reg;
    logic                         old_shown_reg;
    logic [ID_BITS-1:0]           old_idx_reg;
    logic                         req_neg_reg;
    logic [ID_BITS-1:0]           req_idx_reg;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         hit_found_reg;
    logic [HIT_BITS-1:0]          hit_window_reg;
    logic [COUNT_OUT_BITS-1:0]    shown_count_reg;
    logic signed [WLEVEL_BITS-1:0] window_level_reg;

    logic                         in_accept;
    logic                         res_go;
    logic [ID_BITS-1:0]           w;
    logic                         id_ok;

    cell_op_t                     cell_op   [MAX_WINDOWS];
    cell_data_t                   cell_data [MAX_WINDOWS];
    cell_data_t                   load_data;
    cell_bcast_t                  bcast;
    logic [MAX_WINDOWS-1:0]       hit_vec;
    logic [MAX_WINDOWS-1:0]       match_vec;
    logic [MAX_WINDOWS-1:0]       valid_mask;
    logic [MAX_WINDOWS-1:0]       shown_vec;
    logic [MAX_WINDOWS-1:0]       hit_mask;
    logic                         is_shown;
    logic [ID_BITS-1:0]           height;
    logic [ID_BITS-1:0]           hit_idx;

    logic signed [REQ_BITS-1:0]   cnt_s;
    logic signed [REQ_BITS-1:0]   lim;
    logic signed [REQ_BITS-1:0]   req_raw;
    logic signed [REQ_BITS-1:0]   req_c;

    logic                         ins;
    logic                         rem;
    logic                         tab_move_en;
    logic                         tab_size_en;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign res_go    = (state_reg == S_RESULT) && (!out_valid_reg || !out_stall);
    assign w         = ID_BITS'(id_reg);
    assign id_ok     = (int'(id_reg) < MAX_WINDOWS);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_accept) state_next = S_LOOK;
            S_LOOK:   state_next = S_APPLY;
            S_APPLY:  state_next = S_RESULT;
            S_RESULT: if (res_go) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= cmd_t'(cmd);
            id_reg  <= window_id;
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            sw_reg  <= size_w;
            sh_reg  <= size_h;
            lvl_reg <= level;
        end
    end

    // Which cells lie inside the stack, and where the addressed window sits.
    always_comb
    begin
        height = '0;
        for (int i = 0; i < MAX_WINDOWS; i++)
        begin
            valid_mask[i] = (CNT_BITS'(i) < count_reg);
        end
        shown_vec = match_vec & valid_mask;
        is_shown  = |shown_vec;
        for (int i = 0; i < MAX_WINDOWS; i++)
        begin
            if (shown_vec[i])
            begin
                height = height | ID_BITS'(i);
            end
        end
    end

    // Level clamp: a shown window may go no higher than count-1.
    always_comb
    begin
        cnt_s   = REQ_BITS'($signed({1'b0, count_reg}));
        lim     = is_shown ? (cnt_s - REQ_ONE) : cnt_s;
        req_raw = (cmd_reg == CMD_SET_SIZE) ? REQ_MINUS_ONE : REQ_BITS'(lvl_reg);
        if (req_raw < REQ_MINUS_ONE)
        begin
            req_c = REQ_MINUS_ONE;
        end
        else if (req_raw > lim)
        begin
            req_c = lim;
        end
        else
        begin
            req_c = req_raw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOOK)
        begin
            do_level_reg  <= id_ok && ((cmd_reg == CMD_SET_SIZE) || (cmd_reg == CMD_SET_LEVEL));
            old_shown_reg <= is_shown;
            old_idx_reg   <= height;
            req_neg_reg   <= req_c[REQ_BITS-1];
            req_idx_reg   <= ID_BITS'(req_c);
        end
    end

    // Shift control for the row. Removal pulls the upper cells down by one;
    // insertion shifts the cells from the new height to the old one (or the top).
    assign ins = (state_reg == S_APPLY) && do_level_reg && !req_neg_reg;
    assign rem = (state_reg == S_APPLY) && do_level_reg && req_neg_reg && old_shown_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_WINDOWS; i++)
        begin
            cell_op[i] = OP_HOLD;
            if (ins && (ID_BITS'(i) == req_idx_reg))
            begin
                cell_op[i] = OP_LOAD;
            end
            else if (ins && old_shown_reg && (old_idx_reg < req_idx_reg) &&
                     (ID_BITS'(i) >= old_idx_reg) && (ID_BITS'(i) < req_idx_reg))
            begin
                cell_op[i] = OP_NEXT;
            end
            else if (ins && (!old_shown_reg || (old_idx_reg > req_idx_reg)) &&
                     (ID_BITS'(i) > req_idx_reg) &&
                     (old_shown_reg ? (ID_BITS'(i) <= old_idx_reg)
                                    : (CNT_BITS'(i) <= count_reg)))
            begin
                cell_op[i] = OP_PREV;
            end
            else if (rem && (ID_BITS'(i) >= old_idx_reg) && (CNT_BITS'(i + 1) < count_reg))
            begin
                cell_op[i] = OP_NEXT;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins && !old_shown_reg)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (rem)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign tab_move_en = (state_reg == S_APPLY) && id_ok && (cmd_reg == CMD_MOVE);
    assign tab_size_en = (state_reg == S_APPLY) && id_ok && (cmd_reg == CMD_SET_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOWS; i++)
            begin
                tab_left_reg[i]  <= '0;
                tab_top_reg[i]   <= '0;
                tab_width_reg[i] <= '0;
                tab_tall_reg[i]  <= '0;
            end
        end
        else
        begin
            if (tab_move_en)
            begin
                tab_left_reg[w] <= px_reg;
                tab_top_reg[w]  <= py_reg;
            end
            if (tab_size_en)
            begin
                tab_width_reg[w] <= sw_reg;
                tab_tall_reg[w]  <= sh_reg;
            end
        end
    end

    always_comb
    begin
        load_data.id    = w;
        load_data.left  = tab_left_reg[w];
        load_data.top   = tab_top_reg[w];
        load_data.width = tab_width_reg[w];
        load_data.tall  = tab_tall_reg[w];

        bcast.move_en  = tab_move_en;
        bcast.sel_id   = w;
        bcast.new_left = px_reg;
        bcast.new_top  = py_reg;
        bcast.probe_x  = px_reg;
        bcast.probe_y  = py_reg;
    end

    for (genvar g = 0; g < MAX_WINDOWS; g++)
    begin : g_cell
        wsht_cell u_cell (
            .clk       (clk),
            .op        (cell_op[g]),
            .bcast     (bcast),
            .load_data (load_data),
            .prev_data (cell_data[(g == 0) ? 0 : (g - 1)]),
            .next_data (cell_data[(g == MAX_WINDOWS - 1) ? g : (g + 1)]),
            .data      (cell_data[g]),
            .hit       (hit_vec[g]),
            .match     (match_vec[g])
        );
    end

    // The hit test skips the bottom entry and the topmost entry; the highest
    // remaining covering cell wins.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < MAX_WINDOWS; i++)
        begin
            hit_mask[i] = hit_vec[i] && (i > 0) &&
                          ((CNT_BITS+1)'(i + 2) <= (CNT_BITS+1)'(count_reg));
        end
        for (int i = 0; i < MAX_WINDOWS; i++)
        begin
            if (hit_mask[i])
            begin
                hit_idx = cell_data[i].id;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_go)
        begin
            hit_found_reg   <= (cmd_reg == CMD_HIT_TEST) && (|hit_mask);
            hit_window_reg  <= ((cmd_reg == CMD_HIT_TEST) && (|hit_mask)) ?
                               HIT_BITS'(hit_idx) : '0;
            shown_count_reg <= COUNT_OUT_BITS'(count_reg);
            window_level_reg <= (id_ok && is_shown) ? WLEVEL_BITS'(height) : '1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit_found    = hit_found_reg;
    assign hit_window   = hit_window_reg;
    assign shown_count  = shown_count_reg;
    assign window_level = window_level_reg;

    `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CNT_BITS'(MAX_WINDOWS), "stack count beyond table size")
    `ASSERT_IMPLIES(a_unique_shown, clk, rst_n, state_reg == S_RESULT, $onehot0(shown_vec), "window appears twice in the stack")
    `ASSERT_NEXT(a_count_only_apply, clk, rst_n, state_reg != S_APPLY, $stable(count_reg), "stack count changed outside the shift cycle")
    `ASSERT_NEXT(a_result_loads, clk, rst_n, res_go, out_valid_reg, "finished transaction did not reach the output register")

endmodule

[design/wsht_cell.sv]
// One height of the z-order stack: holds a window slot and its rectangle.
// Shifts with its neighbors and tests the probe point; depends on wsht_pkg.
`timescale 1ns / 1ps

module wsht_cell (
    input  logic                 clk,
    input  wsht_pkg::cell_op_t   op,
    input  wsht_pkg::cell_bcast_t bcast,
    input  wsht_pkg::cell_data_t load_data,
    input  wsht_pkg::cell_data_t prev_data,
    input  wsht_pkg::cell_data_t next_data,
    output wsht_pkg::cell_data_t data,
    output logic                 hit,
    output logic                 match
);
    import wsht_pkg::*;

    cell_data_t                 data_reg;
    cell_data_t                 data_next;
    logic                       hit_reg;
    logic                       hit_next;
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            OP_PREV: data_next = prev_data;
            OP_NEXT: data_next = next_data;
            OP_LOAD: data_next = load_data;
            default:
            begin
                // A move of a shown window updates the copy held here.
                if (bcast.move_en && (data_reg.id == bcast.sel_id))
                begin
                    data_next.left = bcast.new_left;
                    data_next.top  = bcast.new_top;
                end
            end
        endcase
    end

    // The offsets are checked as non-negative and below the size.
    always_comb
    begin
        dx = (COORD_BITS+1)'(bcast.probe_x) - (COORD_BITS+1)'(data_reg.left);
        dy = (COORD_BITS+1)'(bcast.probe_y) - (COORD_BITS+1)'(data_reg.top);
        hit_next = !dx[COORD_BITS] && (dx[COORD_BITS-1:0] < data_reg.width) &&
                   !dy[COORD_BITS] && (dy[COORD_BITS-1:0] < data_reg.tall);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
    end

    assign data  = data_reg;
    assign hit   = hit_reg;
    assign match = (data_reg.id == bcast.sel_id);

endmodule
